[src/ttc_pkg.sv]
// Package for the tap tempo clock generator: shared constants and types.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ttc_pkg;

   // Default width of the interval and phase timers and of the stored period.
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // Configuration port geometry: one 32-bit register at byte address 0.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register index, taken from the word address bit of the port.
   localparam logic REG_HOLD_CLEAR = 1'b0;

   // Reset value of the hold limit.
   localparam logic [CSR_DATA_W-1:0] HOLD_CLEAR_RESET = 32'd800000;

   typedef struct packed {
      logic clock_out;
      logic tempo_set;
   } ttc_result_type;

endpackage

`default_nettype wire

[src/ttc_csr.sv]
// Configuration register file of the tap tempo clock generator (APB style).
// Depends on ttc_pkg.
`default_nettype none

module ttc_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [ttc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  [ttc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ttc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [ttc_pkg::CSR_DATA_W-1:0]   hold_clear_ticks
);
   import ttc_pkg::*;

   logic [CSR_DATA_W-1:0] hold_ff;
   logic [CSR_DATA_W-1:0] hold_in;
   logic                  reg_index;
   logic                  write_en;

   // Bit 2 of the byte address selects the register word.
   assign reg_index = csr_paddr[2];
   assign write_en  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      hold_in = hold_ff;
      if (write_en && (reg_index == REG_HOLD_CLEAR)) begin
         hold_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_CLEAR_RESET;
      end else begin
         hold_ff <= hold_in;
      end
   end

   assign csr_pready       = 1'b1;
   assign csr_prdata       = (reg_index == REG_HOLD_CLEAR) ? hold_ff : '0;
   assign hold_clear_ticks = hold_ff;

endmodule

`default_nettype wire

[src/ttc_core.sv]
// Tempo state and per-tick update of the tap tempo clock generator.
// Depends on ttc_pkg.
`default_nettype none

module ttc_core #(
   parameter int COUNT_WIDTH = ttc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             accept,
   input  wire                             tap_pressed,
   input  wire  [ttc_pkg::CSR_DATA_W-1:0]  hold_clear_ticks,
   output ttc_pkg::ttc_result_type         result
);
   import ttc_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > CSR_DATA_W) ? COUNT_WIDTH : CSR_DATA_W;
   localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

   logic [COUNT_WIDTH-1:0] interval_ff, interval_in;
   logic [COUNT_WIDTH-1:0] phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] period_ff, period_in;
   logic                   held_ff, held_in;
   logic                   released_ff, released_in;
   logic                   level_ff, level_in;

   logic [COUNT_WIDTH-1:0] interval_inc;
   logic [COUNT_WIDTH-1:0] phase_inc;
   logic [COUNT_WIDTH-1:0] period_mid;
   logic [COUNT_WIDTH-1:0] phase_mid;
   logic                   level_mid;
   logic                   hold_expired;

   // Both timers stop at all ones rather than wrapping.
   assign interval_inc = (interval_ff == '1) ? interval_ff : interval_ff + ONE;
   assign phase_inc    = (phase_ff == '1) ? phase_ff : phase_ff + ONE;
   assign hold_expired = CMP_W'(interval_inc) > CMP_W'(hold_clear_ticks);

   always_comb begin
      interval_in = interval_inc;
      phase_mid   = phase_inc;
      period_mid  = period_ff;
      held_in     = held_ff;
      released_in = released_ff;
      level_mid   = level_ff;

      // Button handling.
      if (tap_pressed) begin
         released_in = 1'b0;
         if (!held_ff) begin
            held_in     = 1'b1;
            period_mid  = interval_inc;
            interval_in = '0;
            phase_mid   = '0;
            level_mid   = 1'b1;
         end else if (hold_expired) begin
            period_mid = '0;
            phase_mid  = '0;
            level_mid  = 1'b0;
         end
      end else begin
         held_in = 1'b0;
         if (!released_ff) begin
            level_mid   = 1'b0;
            released_in = 1'b1;
         end
      end

      // Clock output from the phase timer and the period.
      period_in = period_mid;
      phase_in  = phase_mid;
      level_in  = level_mid;
      if (period_mid != '0) begin
         if (phase_mid >= (period_mid >> 1)) begin
            level_in = 1'b0;
         end
         if (phase_mid > period_mid) begin
            phase_in = phase_mid - period_mid;
            level_in = 1'b1;
         end
      end else begin
         level_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         phase_ff    <= '0;
         period_ff   <= '0;
         held_ff     <= 1'b0;
         released_ff <= 1'b0;
         level_ff    <= 1'b0;
      end else if (accept) begin
         interval_ff <= interval_in;
         phase_ff    <= phase_in;
         period_ff   <= period_in;
         held_ff     <= held_in;
         released_ff <= released_in;
         level_ff    <= level_in;
      end
   end

   assign result.clock_out = level_in;
   assign result.tempo_set = (period_in != '0);

   a_no_tempo_low : assert property (@(posedge clock) disable iff (reset)
      (period_ff == '0) |-> !level_ff)
      else $error("clock output high with no tempo stored");

   a_phase_bounded : assert property (@(posedge clock) disable iff (reset)
      (period_ff != '0) |-> (phase_ff <= period_ff))
      else $error("phase timer beyond the stored period");

   a_held_released_excl : assert property (@(posedge clock) disable iff (reset)
      !(held_ff && released_ff))
      else $error("button both held and released");

endmodule

`default_nettype wire

[src/ttc_out.sv]
// Result register with a skid stage for the tap tempo clock generator.
// Depends on ttc_pkg.
`default_nettype none

module ttc_out (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  wire ttc_pkg::ttc_result_type push_result,
   output logic                     can_push,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic                     rsp_clock_out,
   output logic                     rsp_tempo_set
);
   import ttc_pkg::*;

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   ttc_result_type out_data_ff, out_data_in;
   ttc_result_type skid_data_ff, skid_data_in;
   logic           out_free;

   // The output slot frees up when it is empty or being taken this cycle.
   assign out_free = !out_valid_ff || rsp_ready;
   assign can_push = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_result;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_clock_out = out_data_ff.clock_out;
   assign rsp_tempo_set = out_data_ff.tempo_set;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a request while the output is empty");

   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid stage did not move into the output register");

endmodule

`default_nettype wire

[src/tap_tempo_clock_generator.sv]
// Tap tempo clock generator top level: CSR block, tempo core, result buffer.
// Depends on ttc_pkg, ttc_csr, ttc_core and ttc_out.
// A result is offered from the output register, or waits first in the skid
// stage while the output stalls. Throughput: one request per cycle while the
// skid stage is empty, so requests keep flowing while one result waits.
// Reset: synchronous; timers, period and flags clear, hold limit is 800000.
`default_nettype none

module tap_tempo_clock_generator #(
   parameter int COUNT_WIDTH = ttc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire                             req_tap_pressed,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic                            rsp_clock_out,
   output logic                            rsp_tempo_set,
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire  [ttc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [ttc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ttc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import ttc_pkg::*;

   logic [CSR_DATA_W-1:0] hold_clear_ticks;
   logic                  accept;
   ttc_result_type        result;

   assign accept = req_valid && req_ready;

   ttc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .hold_clear_ticks (hold_clear_ticks)
   );

   ttc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .tap_pressed      (req_tap_pressed),
      .hold_clear_ticks (hold_clear_ticks),
      .result           (result)
   );

   ttc_out u_out (
      .clock         (clock),
      .reset         (reset),
      .push          (accept),
      .push_result   (result),
      .can_push      (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_clock_out (rsp_clock_out),
      .rsp_tempo_set (rsp_tempo_set)
   );

endmodule

`default_nettype wire

[tb/tb_tap_tempo_clock_generator.sv]
// Self-checking testbench for the tap tempo clock generator: drives tap ticks,
// writes the hold limit and checks every response against a built-in predictor
// or a typed-in value. Depends on ttc_pkg and the tap_tempo_clock_generator top level only.

module tb_tap_tempo_clock_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import ttc_pkg::*;

   localparam int COUNT_W         = COUNT_WIDTH_DEFAULT;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DIRECTED_ROWS   = 24;
   localparam int PHASES          = 10;
   localparam int PHASE_TAPS      = 60;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int MAX_PRINTS      = 30;

   localparam logic [CSR_ADDR_W-1:0] HOLD_ADDR   = {REG_HOLD_CLEAR, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = {~REG_HOLD_CLEAR, 2'b00};
   localparam logic [CSR_DATA_W-1:0] HOLD_MIN    = 32'd1;
   localparam logic [CSR_DATA_W-1:0] HOLD_MAX    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic                  tap;
      logic                  wr_hold;
      logic [CSR_DATA_W-1:0] hold_val;
      logic                  pinned;
      logic                  clk;
      logic                  tset;
   } tap_row_type;

   typedef struct {
      bit             pinned;
      ttc_result_type val;
   } pin_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid       = 1'b0;
   logic                  req_tap_pressed = 1'b0;
   logic                  req_ready;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic                  rsp_clock_out;
   logic                  rsp_tempo_set;
   logic                  csr_psel        = 1'b0;
   logic                  csr_penable     = 1'b0;
   logic                  csr_pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr       = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata      = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state, mirroring the block after reset.
   logic [COUNT_W-1:0]    since_tap    = '0;
   logic [COUNT_W-1:0]    phase_ticks  = '0;
   logic [COUNT_W-1:0]    period       = '0;
   bit                    was_pressed  = 1'b0;
   bit                    release_seen = 1'b0;
   bit                    level        = 1'b0;
   logic [CSR_DATA_W-1:0] hold_limit   = HOLD_CLEAR_RESET;

   ttc_result_type pending_outputs[$];
   pin_entry_type  pinned_outputs[$];

   int  errors        = 0;
   int  taps_sent     = 0;
   int  outputs_seen  = 0;
   int  hold_writes   = 0;
   bit  quiet         = 1'b0;
   bit  hold_off_req  = 1'b0;

   // Directed ticks: tap level, optional hold limit write before the tick, and
   // a typed-in response where it is obvious.
   tap_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b0, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0},  // straight after reset: low, no tempo
      '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},  // first press sets period from reset
      '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b1, HOLD_MIN, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0},  // hold beyond the limit clears tempo
      '{1'b1, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b1, HOLD_MAX, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0}
   };

   tap_tempo_clock_generator #(
      .COUNT_WIDTH (COUNT_W)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_tap_pressed (req_tap_pressed),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_clock_out   (rsp_clock_out),
      .rsp_tempo_set   (rsp_tempo_set),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // One tick of the tempo logic: timers first, then the button, then the output.
   function automatic ttc_result_type tempo_step(input bit pressed);
      ttc_result_type res;
      if (since_tap != '1) since_tap = since_tap + 1'b1;
      if (phase_ticks != '1) phase_ticks = phase_ticks + 1'b1;
      if (pressed) begin
         release_seen = 1'b0;
         if (!was_pressed) begin
            was_pressed = 1'b1;
            period      = since_tap;
            since_tap   = '0;
            phase_ticks = '0;
            level       = 1'b1;
         end else if (since_tap > hold_limit) begin
            period      = '0;
            phase_ticks = '0;
            level       = 1'b0;
         end
      end else begin
         was_pressed = 1'b0;
         if (!release_seen) begin
            level        = 1'b0;
            release_seen = 1'b1;
         end
      end
      if (period != '0) begin
         if (phase_ticks >= (period >> 1)) level = 1'b0;
         if (phase_ticks > period) begin
            phase_ticks = phase_ticks - period;
            level       = 1'b1;
         end
      end else begin
         level = 1'b0;
      end
      res.clock_out = level;
      res.tempo_set = (period != '0);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("MISMATCH %s: got %0h, expected %0h (request %0d)", what, got, want,
                  outputs_seen);
   endtask

   // Each accepted request is stepped through the predictor straight away.
   always @(posedge clock) begin : request_monitor
      ttc_result_type predicted;
      pin_entry_type  pin;
      if (!reset && req_valid && req_ready) begin
         predicted = tempo_step(req_tap_pressed);
         pin = pinned_outputs.pop_front();
         pending_outputs.push_back(pin.pinned ? pin.val : predicted);
      end
   end

   always @(posedge clock) begin : response_monitor
      ttc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         outputs_seen++;
         if (pending_outputs.size() == 0) begin
            report_mismatch("response with no request outstanding",
                            {rsp_clock_out, rsp_tempo_set}, 0);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_clock_out !== want.clock_out)
               report_mismatch("clock_out", rsp_clock_out, want.clock_out);
            if (rsp_tempo_set !== want.tempo_set)
               report_mismatch("tempo_set", rsp_tempo_set, want.tempo_set);
         end
      end
   end

   // Response side: random stalls, one long hold-off on request, none at the end.
   initial begin : response_driver
      forever begin
         if (quiet) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles with %0d responses outstanding", CYCLE_LIMIT,
               pending_outputs.size());
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_tap(input bit pressed, input bit pin, input ttc_result_type pin_val);
      pin_entry_type e;
      e.pinned = pin;
      e.val    = pin_val;
      pinned_outputs.push_back(e);
      req_valid       <= 1'b1;
      req_tap_pressed <= pressed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      taps_sent++;
   endtask

   task automatic idle_requests(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic offer_tap(input bit pressed);
      if (!quiet && $urandom_range(0, 11) == 0) idle_requests($urandom_range(1, 19));
      send_tap(pressed, 1'b0, '0);
   endtask

   // Stop offering and wait until every outstanding response has been taken.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == HOLD_ADDR) hold_limit = data;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_hold_readback();
      logic [CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= HOLD_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      if (got !== hold_limit) report_mismatch("hold limit readback", got, hold_limit);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_hold(input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_write(HOLD_ADDR, value);
      check_hold_readback();
      hold_writes++;
   endtask

   initial begin : stimulus
      ttc_result_type        pin_val;
      logic [CSR_DATA_W-1:0] new_hold;
      int                    burst;
      int                    press_len;
      int                    gap_len;
      int                    n;
      bit                    paused;

      paused = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_hold_readback();

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].wr_hold) set_hold(directed_rows[i].hold_val);
         pin_val.clock_out = directed_rows[i].clk;
         pin_val.tempo_set = directed_rows[i].tset;
         send_tap(directed_rows[i].tap, directed_rows[i].pinned, pin_val);
      end

      // A write to the unused register index must leave the hold limit alone.
      settle();
      csr_write(UNUSED_ADDR, $urandom);
      check_hold_readback();

      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       new_hold = HOLD_MIN;
            1:       new_hold = HOLD_MAX;
            2, 3:    new_hold = $urandom_range(2, 40);
            4:       new_hold = $urandom_range(41, 200);
            default: new_hold = $urandom;
         endcase
         set_hold(new_hold);
         if ($urandom_range(0, 2) == 0) begin
            csr_write(UNUSED_ADDR, $urandom);
            check_hold_readback();
         end
         if (phase == PHASES - 1) quiet = 1'b1;
         // Early on the response side holds off long enough for the block to back up.
         if (phase == 2) hold_off_req = 1'b1;

         n = 0;
         while (n < PHASE_TAPS) begin
            if (phase == 5 && n >= PHASE_TAPS / 2 && !paused) begin
               settle();
               paused = 1'b1;
            end
            case ($urandom_range(0, 9))
               0: begin
                  burst = $urandom_range(1, 8);
                  repeat (burst) offer_tap($urandom_range(0, 1));
                  n += burst;
               end
               1: begin
                  // A hold long enough to pass the limit where the limit is small.
                  if (hold_limit < 250) press_len = int'(hold_limit) + $urandom_range(1, 10);
                  else press_len = $urandom_range(1, 300);
                  gap_len = $urandom_range(1, 10);
                  repeat (press_len) offer_tap(1'b1);
                  repeat (gap_len) offer_tap(1'b0);
                  n += press_len + gap_len;
               end
               default: begin
                  press_len = $urandom_range(1, 6);
                  gap_len   = $urandom_range(1, 60);
                  repeat (press_len) offer_tap(1'b1);
                  repeat (gap_len) offer_tap(1'b0);
                  n += press_len + gap_len;
               end
            endcase
         end
      end

      settle();
      $display("Covered %0d tap ticks and %0d responses over %0d hold limit settings,",
               taps_sent, outputs_seen, hold_writes);
      $display("including the minimum and maximum limits and ignored register writes.");
      if (errors == 0 && pending_outputs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
src/ttc_pkg.sv
src/ttc_csr.sv
src/ttc_core.sv
src/ttc_out.sv
src/tap_tempo_clock_generator.sv
tb/tb_tap_tempo_clock_generator.sv
